// File: rtl/layer_norm_row_engine_unit_macros.svh
// Assertion macros used by the checker file of the row normalization engine.
// No dependencies.
`ifndef LAYER_NORM_ROW_ENGINE_UNIT_MACROS_SVH
`define LAYER_NORM_ROW_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LNR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define LNR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/lnr_pkg.sv
// Shared types and constants of the row normalization engine.
// No dependencies.
package lnr_pkg;

    localparam int DATA_W  = 16;
    localparam int INV_W   = 24;
    localparam int ADDR_W  = 6;
    localparam int CNT_W   = 7;
    localparam int SUM_W   = 22;
    localparam int MEAN_W  = 17;
    localparam int AD_W    = 17;
    localparam int SQ_W    = 34;
    localparam int SUMSQ_W = 40;
    localparam int DIVD_W  = 49;
    localparam int DIVS_W  = 33;
    localparam int VAR_W   = 32;
    localparam int M1_W    = 41;
    localparam int P_W     = 57;
    localparam int RND_W   = 25;
    localparam int CLP_W   = 17;
    localparam int Y_W     = 19;
    localparam int BIT_W   = 5;
    localparam int RAM_W   = 3 * DATA_W;

    localparam logic [CLP_W-1:0] R_CLAMP = 17'd131068;

    localparam logic [1:0] DIV_MEAN = 2'd0;
    localparam logic [1:0] DIV_VAR  = 2'd1;
    localparam logic [1:0] DIV_LIM  = 2'd2;

    typedef struct packed {
        logic signed [DATA_W-1:0] sample;
        logic signed [DATA_W-1:0] scale_value;
        logic signed [DATA_W-1:0] bias_value;
        logic                     last_in_row;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] normalized_value;
        logic signed [DATA_W-1:0] row_mean;
        logic [INV_W-1:0]         inv_std;
        logic                     row_overflow;
        logic                     last_out;
    } t_out_item;

    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [ADDR_W-1:0] addr;
        logic [CNT_W-1:0]  cnt;
        logic              acc_clr;
        logic              sum_rd;
        logic              var_rd;
        logic              div_start;
        logic [1:0]        div_sel;
        logic              root_init;
        logic              root_ones;
        logic              root_step;
        logic [BIT_W-1:0]  root_bit;
        logic              om1;
        logic              om2;
        logic              out_load;
        logic              out_last;
        logic              out_ovf;
    } t_cmd;

    typedef struct packed {
        logic acc_busy;
        logic div_done;
        logic v_zero;
        logic out_free;
    } t_status;

endpackage

// File: rtl/lnr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lnr_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;
endmodule

// File: rtl/lnr_div.sv
// Restoring divider, one quotient bit per cycle, shared by all row divisions.
// Depends on lnr_pkg.
module lnr_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [lnr_pkg::DIVD_W-1:0]  i_dividend,
    input  logic [lnr_pkg::DIVS_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [lnr_pkg::DIVD_W-1:0]  o_quotient
);
    logic                        r_busy;
    logic                        r_done;
    logic [5:0]                  r_cnt;
    logic [lnr_pkg::DIVS_W-1:0]  r_rem;
    logic [lnr_pkg::DIVD_W-1:0]  r_quo;
    logic [lnr_pkg::DIVS_W-1:0]  r_div;
    logic [lnr_pkg::DIVS_W:0]    w_sh;
    logic [lnr_pkg::DIVS_W:0]    w_sub;
    logic                        w_ge;

    assign w_sh  = {r_rem, r_quo[lnr_pkg::DIVD_W-1]};
    assign w_ge  = w_sh >= {1'b0, r_div};
    assign w_sub = w_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(lnr_pkg::DIVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_sub[lnr_pkg::DIVS_W-1:0] : w_sh[lnr_pkg::DIVS_W-1:0];
            r_quo <= {r_quo[lnr_pkg::DIVD_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

// File: rtl/lnr_dp.sv
// Datapath: row buffer, accumulators, divider, inverse root and output register.
// Depends on lnr_pkg, lnr_ram and lnr_div.
module lnr_dp #(
    parameter int ROW_LEN = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lnr_pkg::t_cmd        i_cmd,
    output lnr_pkg::t_status     o_status,
    input  lnr_pkg::t_in_item    i_in_item,
    input  logic                 i_cfg_valid,
    input  logic [15:0]          i_cfg_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output lnr_pkg::t_out_item   o_out
);
    localparam int AW = ROW_LEN > 1 ? $clog2(ROW_LEN) : 1;

    logic [lnr_pkg::RAM_W-1:0]          w_rdata;
    logic signed [lnr_pkg::DATA_W-1:0]  w_sample;
    logic signed [lnr_pkg::DATA_W-1:0]  w_scale;
    logic signed [lnr_pkg::DATA_W-1:0]  w_bias;

    logic [15:0]                        r_eps;
    logic                               r_sum_pend;
    logic                               r_var_pend;
    logic                               r_sq_pend;
    logic signed [lnr_pkg::SUM_W-1:0]   r_sum;
    logic [lnr_pkg::SQ_W-1:0]           r_sq;
    logic [lnr_pkg::SUMSQ_W-1:0]        r_sumsq;
    logic signed [lnr_pkg::MEAN_W-1:0]  r_mean;
    logic [lnr_pkg::DIVS_W-1:0]         r_v;
    logic [lnr_pkg::DIVD_W-1:0]         r_lim;
    logic [lnr_pkg::INV_W-1:0]          r_inv;
    logic [1:0]                         r_div_sel;
    logic [lnr_pkg::M1_W-1:0]           r_m1;
    logic [lnr_pkg::DATA_W-1:0]         r_as;
    logic                               r_neg;
    logic signed [lnr_pkg::DATA_W-1:0]  r_bias;
    logic [lnr_pkg::P_W-1:0]            r_p;
    logic                               r_out_valid;
    lnr_pkg::t_out_item                 r_out;

    logic signed [lnr_pkg::MEAN_W:0]    w_d;
    logic [lnr_pkg::AD_W-1:0]           w_ad;
    logic [lnr_pkg::DATA_W-1:0]         w_as;
    logic [lnr_pkg::SUM_W-1:0]          w_asum;
    logic [lnr_pkg::DIVD_W-1:0]         w_half;
    logic [lnr_pkg::DIVD_W-1:0]         w_dvd;
    logic [lnr_pkg::DIVS_W-1:0]         w_dvs;
    logic                               w_done;
    logic [lnr_pkg::DIVD_W-1:0]         w_quo;
    logic [lnr_pkg::MEAN_W-1:0]         w_m;
    logic [lnr_pkg::VAR_W-1:0]          w_var;
    logic [lnr_pkg::INV_W-1:0]          w_t;
    logic [2*lnr_pkg::INV_W-1:0]        w_tt;
    logic [lnr_pkg::P_W-1:0]            w_pr;
    logic [lnr_pkg::RND_W-1:0]          w_r;
    logic [lnr_pkg::CLP_W-1:0]          w_rc;
    logic signed [lnr_pkg::Y_W-1:0]     w_mag;
    logic signed [lnr_pkg::Y_W-1:0]     w_y;
    logic signed [lnr_pkg::DATA_W-1:0]  w_ysat;

    lnr_ram #(
        .WIDTH (lnr_pkg::RAM_W),
        .DEPTH (ROW_LEN)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (i_cmd.addr[AW-1:0]),
        .i_wdata ({i_in_item.sample, i_in_item.scale_value, i_in_item.bias_value}),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_cmd.addr[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_sample = w_rdata[3*lnr_pkg::DATA_W-1:2*lnr_pkg::DATA_W];
    assign w_scale  = w_rdata[2*lnr_pkg::DATA_W-1:lnr_pkg::DATA_W];
    assign w_bias   = w_rdata[lnr_pkg::DATA_W-1:0];

    assign w_d  = (lnr_pkg::MEAN_W+1)'(w_sample) - (lnr_pkg::MEAN_W+1)'(r_mean);
    assign w_ad = w_d[lnr_pkg::MEAN_W] ? lnr_pkg::AD_W'(-w_d) : lnr_pkg::AD_W'(w_d);
    assign w_as = w_scale[lnr_pkg::DATA_W-1] ? lnr_pkg::DATA_W'(-w_scale)
                                             : lnr_pkg::DATA_W'(w_scale);

    assign w_asum = r_sum[lnr_pkg::SUM_W-1] ? lnr_pkg::SUM_W'(-r_sum)
                                            : lnr_pkg::SUM_W'(r_sum);
    assign w_half = lnr_pkg::DIVD_W'(i_cmd.cnt >> 1);

    always_comb begin
        w_dvd = lnr_pkg::DIVD_W'(1) << (lnr_pkg::DIVD_W - 1);
        w_dvs = r_v;
        case (i_cmd.div_sel)
            lnr_pkg::DIV_MEAN: begin
                w_dvd = lnr_pkg::DIVD_W'(w_asum) + w_half;
                w_dvs = lnr_pkg::DIVS_W'(i_cmd.cnt);
            end
            lnr_pkg::DIV_VAR: begin
                w_dvd = lnr_pkg::DIVD_W'(r_sumsq) + w_half;
                w_dvs = lnr_pkg::DIVS_W'(i_cmd.cnt);
            end
            default: begin
                w_dvd = lnr_pkg::DIVD_W'(1) << (lnr_pkg::DIVD_W - 1);
                w_dvs = r_v;
            end
        endcase
    end

    lnr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_done     (w_done),
        .o_quotient (w_quo)
    );

    assign w_m   = w_quo[lnr_pkg::MEAN_W-1:0];
    assign w_var = (w_quo > lnr_pkg::DIVD_W'({lnr_pkg::VAR_W{1'b1}}))
                 ? {lnr_pkg::VAR_W{1'b1}} : w_quo[lnr_pkg::VAR_W-1:0];

    assign w_t  = r_inv | (lnr_pkg::INV_W'(1) << i_cmd.root_bit);
    assign w_tt = w_t * w_t;

    assign w_pr   = r_p + (lnr_pkg::P_W'(1) << 31);
    assign w_r    = w_pr[lnr_pkg::P_W-1:32];
    assign w_rc   = (w_r > lnr_pkg::RND_W'(lnr_pkg::R_CLAMP)) ? lnr_pkg::R_CLAMP
                                                              : w_r[lnr_pkg::CLP_W-1:0];
    assign w_mag  = r_neg ? -lnr_pkg::Y_W'({2'b00, w_rc}) : lnr_pkg::Y_W'({2'b00, w_rc});
    assign w_y    = w_mag + lnr_pkg::Y_W'(r_bias);
    assign w_ysat = (w_y > lnr_pkg::Y_W'(32767)) ? 16'sh7FFF
                  : (w_y < -lnr_pkg::Y_W'(32768)) ? 16'sh8000
                  : w_y[lnr_pkg::DATA_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps       <= 16'd1;
            r_sum_pend  <= 1'b0;
            r_var_pend  <= 1'b0;
            r_sq_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_eps <= i_cfg_data;
            end
            r_sum_pend <= i_cmd.sum_rd;
            r_var_pend <= i_cmd.var_rd;
            r_sq_pend  <= r_var_pend;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_clr) begin
            r_sum   <= '0;
            r_sumsq <= '0;
        end else begin
            if (r_sum_pend) begin
                r_sum <= r_sum + lnr_pkg::SUM_W'(w_sample);
            end
            if (r_sq_pend) begin
                r_sumsq <= r_sumsq + lnr_pkg::SUMSQ_W'(r_sq);
            end
        end
        if (r_var_pend) begin
            r_sq <= w_ad * w_ad;
        end
        if (i_cmd.div_start) begin
            r_div_sel <= i_cmd.div_sel;
        end
        if (w_done) begin
            case (r_div_sel)
                lnr_pkg::DIV_MEAN: begin
                    r_mean <= r_sum[lnr_pkg::SUM_W-1] ? -$signed(w_m) : $signed(w_m);
                end
                lnr_pkg::DIV_VAR: begin
                    r_v <= lnr_pkg::DIVS_W'(w_var) + lnr_pkg::DIVS_W'(r_eps);
                end
                default: begin
                    r_lim <= w_quo;
                end
            endcase
        end
        if (i_cmd.root_init) begin
            r_inv <= '0;
        end else if (i_cmd.root_ones) begin
            r_inv <= '1;
        end else if (i_cmd.root_step && ({1'b0, w_tt} <= r_lim)) begin
            r_inv <= w_t;
        end
        if (i_cmd.om1) begin
            r_m1   <= w_ad * r_inv;
            r_as   <= w_as;
            r_neg  <= w_d[lnr_pkg::MEAN_W] ^ w_scale[lnr_pkg::DATA_W-1];
            r_bias <= w_bias;
        end
        if (i_cmd.om2) begin
            r_p <= r_m1 * r_as;
        end
        if (i_cmd.out_load) begin
            r_out.normalized_value <= w_ysat;
            r_out.row_mean         <= r_mean[lnr_pkg::DATA_W-1:0];
            r_out.inv_std          <= r_inv;
            r_out.row_overflow     <= i_cmd.out_ovf;
            r_out.last_out         <= i_cmd.out_last;
        end
    end

    assign o_status.acc_busy = r_sum_pend | r_var_pend | r_sq_pend;
    assign o_status.div_done = w_done;
    assign o_status.v_zero   = (r_v == '0);
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
endmodule

// File: rtl/lnr_ctrl.sv
// Controller state machine: row loading, statistics passes, divisions, root and output.
// Depends on lnr_pkg.
module lnr_ctrl #(
    parameter int ROW_LEN = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_last,
    output logic              o_in_ready,
    input  lnr_pkg::t_status  i_status,
    output lnr_pkg::t_cmd     o_cmd
);
    localparam int AW = ROW_LEN > 1 ? $clog2(ROW_LEN) : 1;
    localparam int CW = $clog2(ROW_LEN + 1);

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_SUM   = 4'd1;
    localparam logic [3:0] S_SUMW  = 4'd2;
    localparam logic [3:0] S_MDIV  = 4'd3;
    localparam logic [3:0] S_MWAIT = 4'd4;
    localparam logic [3:0] S_VAR   = 4'd5;
    localparam logic [3:0] S_VARW  = 4'd6;
    localparam logic [3:0] S_VDIV  = 4'd7;
    localparam logic [3:0] S_VWAIT = 4'd8;
    localparam logic [3:0] S_LDIV  = 4'd9;
    localparam logic [3:0] S_LWAIT = 4'd10;
    localparam logic [3:0] S_ROOT  = 4'd11;
    localparam logic [3:0] S_ORD   = 4'd12;
    localparam logic [3:0] S_OM1   = 4'd13;
    localparam logic [3:0] S_OM2   = 4'd14;
    localparam logic [3:0] S_OFIN  = 4'd15;

    logic [3:0]                r_state, n_state;
    logic [CW-1:0]             r_cnt, n_cnt;
    logic                      r_ovf, n_ovf;
    logic [CW-1:0]             r_idx, n_idx;
    logic [lnr_pkg::BIT_W-1:0] r_rb, n_rb;
    logic                      w_acc;
    logic                      w_end;

    assign w_acc = (r_state == S_LOAD) && i_in_valid;
    assign w_end = (r_idx == CW'(r_cnt - CW'(1)));

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_ovf   = r_ovf;
        n_idx   = r_idx;
        n_rb    = r_rb;
        o_cmd   = '0;
        o_cmd.cnt      = lnr_pkg::CNT_W'(r_cnt);
        o_cmd.addr     = lnr_pkg::ADDR_W'(r_idx[AW-1:0]);
        o_cmd.root_bit = r_rb;
        o_cmd.out_ovf  = r_ovf;
        o_cmd.out_last = w_end;
        case (r_state)
            S_LOAD: begin
                o_cmd.addr = lnr_pkg::ADDR_W'(r_cnt[AW-1:0]);
                if (w_acc) begin
                    if (r_cnt < CW'(ROW_LEN)) begin
                        o_cmd.wr_en = 1'b1;
                        n_cnt = r_cnt + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in_last) begin
                        o_cmd.acc_clr = 1'b1;
                        n_idx   = '0;
                        n_state = S_SUM;
                    end
                end
            end
            S_SUM: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.sum_rd = 1'b1;
                n_idx = r_idx + CW'(1);
                if (w_end) begin
                    n_state = S_SUMW;
                end
            end
            S_SUMW: begin
                if (!i_status.acc_busy) begin
                    n_state = S_MDIV;
                end
            end
            S_MDIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = lnr_pkg::DIV_MEAN;
                n_state = S_MWAIT;
            end
            S_MWAIT: begin
                if (i_status.div_done) begin
                    n_idx   = '0;
                    n_state = S_VAR;
                end
            end
            S_VAR: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.var_rd = 1'b1;
                n_idx = r_idx + CW'(1);
                if (w_end) begin
                    n_state = S_VARW;
                end
            end
            S_VARW: begin
                if (!i_status.acc_busy) begin
                    n_state = S_VDIV;
                end
            end
            S_VDIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = lnr_pkg::DIV_VAR;
                n_state = S_VWAIT;
            end
            S_VWAIT: begin
                if (i_status.div_done) begin
                    n_state = S_LDIV;
                end
            end
            S_LDIV: begin
                n_idx = '0;
                if (i_status.v_zero) begin
                    o_cmd.root_ones = 1'b1;
                    n_state = S_ORD;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = lnr_pkg::DIV_LIM;
                    o_cmd.root_init = 1'b1;
                    n_state = S_LWAIT;
                end
            end
            S_LWAIT: begin
                if (i_status.div_done) begin
                    n_rb    = lnr_pkg::BIT_W'(lnr_pkg::INV_W - 1);
                    n_state = S_ROOT;
                end
            end
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
                n_rb = r_rb - lnr_pkg::BIT_W'(1);
                if (r_rb == '0) begin
                    n_state = S_ORD;
                end
            end
            S_ORD: begin
                o_cmd.rd_en = 1'b1;
                n_state = S_OM1;
            end
            S_OM1: begin
                o_cmd.om1 = 1'b1;
                n_state = S_OM2;
            end
            S_OM2: begin
                o_cmd.om2 = 1'b1;
                n_state = S_OFIN;
            end
            S_OFIN: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_idx = r_idx + CW'(1);
                    if (w_end) begin
                        n_cnt   = '0;
                        n_ovf   = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        n_state = S_ORD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_idx   <= '0;
            r_rb    <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
            r_idx   <= n_idx;
            r_rb    <= n_rb;
        end
    end

    assign o_in_ready = (r_state == S_LOAD);
endmodule

// File: rtl/layer_norm_row_engine_unit.sv
// Row normalization engine: loads a row of samples, then normalizes, scales and biases it.
// Top level, built from lnr_ctrl and lnr_dp; depends on lnr_pkg.
//
// Input channel: one sample with its scale and bias per transaction; the
// transaction marked last_in_row closes the row. While loading, one input
// transaction is taken per cycle. Elements beyond ROW_LEN are dropped and
// flagged on every result of the row.
// After the last input, the input channel is held off while the row is worked:
// a sum pass, a mean division, a variance pass, a variance division, then a
// reciprocal division and a bit-serial inverse root (both skipped when the
// variance plus epsilon is zero), then each result in turn through the output
// multiplier pipeline; all three divisions use the shared bit-serial divider,
// and each pass reads the row through the single read port of the row buffer.
// Output channel: one result per stored element, in order, from a holding
// register; a stalled receiver stops the output pass until it takes the result.
// The next row can be loaded while the last result still waits to be taken.
// Configuration channel: the epsilon register, always ready, reset value 1.
// Reset clears the row count, overflow flag and control state; the buffer
// needs no clearing.
module layer_norm_row_engine_unit #(
    parameter int ROW_LEN = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lnr_pkg::t_in_item   i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lnr_pkg::t_out_item  o_out,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [15:0]         i_cfg_data
);
    lnr_pkg::t_cmd    w_cmd;
    lnr_pkg::t_status w_status;

    lnr_ctrl #(
        .ROW_LEN (ROW_LEN)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_last  (i_in.last_in_row),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    lnr_dp #(
        .ROW_LEN (ROW_LEN)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_item   (i_in),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    assign o_cfg_ready = 1'b1;
endmodule

// File: rtl/lnr_checker.sv
// Port-level checker for the row normalization engine, bound to the top level.
// Depends on lnr_pkg and layer_norm_row_engine_unit_macros.svh.
`include "layer_norm_row_engine_unit_macros.svh"

module lnr_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input lnr_pkg::t_in_item   i_in,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input lnr_pkg::t_out_item  o_out,
    input logic                i_cfg_valid,
    input logic                o_cfg_ready,
    input logic [15:0]         i_cfg_data
);
    `LNR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out), "Stalled result changed or dropped.")

    `LNR_ASSERT_NOW(a_no_load_mid_row, i_clk, i_rst_n, o_out_valid && !o_out.last_out, !o_in_ready, "Input accepted while a row is being emitted.")

    `LNR_ASSERT_NOW(a_row_stats_stable, i_clk, i_rst_n, o_out_valid && $past(o_out_valid && i_out_ready && !o_out.last_out), o_out.row_mean == $past(o_out.row_mean) && o_out.inv_std == $past(o_out.inv_std), "Row statistics changed within a row.")
endmodule

bind layer_norm_row_engine_unit lnr_checker u_lnr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready),
    .i_cfg_data  (i_cfg_data)
);
